@@ hdl/tpp_pkg.sv @@
`timescale 1ns / 1ps
package tpp_pkg;

  localparam int unsigned TableEntriesDefault = 128;

  localparam logic [7:0]  SyncByte     = 8'h47;
  localparam logic [7:0]  PktLen       = 8'd188;
  localparam logic [7:0]  PcrReportPos = 8'd10;
  localparam logic [31:0] MaxWaitReset = 32'd20000000;

  // x / 90 == (x >> 1) / 45; reciprocal of 45 is 2^32 + RecipLo45, scaled by 2^38
  localparam logic [31:0] RecipLo45    = 32'd1813430637;

  localparam logic [2:0]  FlagsAllSet  = 3'b111;

  localparam int unsigned PidW   = 13;
  localparam int unsigned PcrW   = 33;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned QuoW   = 27;   // 2^33 / 90 fits in 27 bits
  localparam int unsigned TgtW   = 37;   // quotient * 1000

  localparam int unsigned ResKindSyncErr = 0;
  localparam int unsigned ResKindPcr     = 1;

  // register byte offsets
  localparam logic [2:0] RegMaxWait = 3'd0;

  typedef struct packed {
    logic [PidW-1:0]  pid;
    logic [PcrW-1:0]  prev_pcr;
    logic [TimeW-1:0] pace_t0;
    logic             seen;
  } entry_t;

endpackage

@@ hdl/tpp_if.sv @@
`timescale 1ns / 1ps
interface tpp_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  stream_byte;
  logic [63:0] now_us;
  logic        pass_start;
  modport source (output valid, stream_byte, now_us, pass_start, input ready);
  modport sink   (input valid, stream_byte, now_us, pass_start, output ready);
endinterface

interface tpp_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [12:0] pid;
  logic [32:0] pcr_value;
  logic        paced;
  logic [31:0] wait_us;
  modport source (output valid, kind, pid, pcr_value, paced, wait_us, input ready);
  modport sink   (input valid, kind, pid, pcr_value, paced, wait_us, output ready);
endinterface

@@ hdl/tpp_div90.sv @@
`timescale 1ns / 1ps
module tpp_div90 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tpp_pkg::PcrW-1:0]    dividend_i,
  output logic                        done_o,
  output logic [tpp_pkg::QuoW-1:0]    quotient_o
);
  import tpp_pkg::*;

  // divide by 90 as a halving then a reciprocal multiply by 1/45:
  // q = (y * (2^32 + RecipLo45)) >> 38, y = x >> 1
  logic [31:0]     y_q;
  logic [31:0]     yh_q;
  logic [63:0]     prod_q;
  logic [QuoW-1:0] quo_q;
  logic            s1_q, s2_q, done_q;
  logic [64:0]     sum;

  assign sum = {1'b0, yh_q, 32'd0} + {1'b0, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      y_q <= dividend_i[PcrW-1:1];
    end
    if (s1_q) begin
      prod_q <= 64'(y_q) * 64'(RecipLo45);
      yh_q   <= y_q;
    end
    if (s2_q) begin
      quo_q <= sum[64:38];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hdl/ts_pcr_pacing_parser_unit.sv @@
`timescale 1ns / 1ps
// A sync error result is valid the cycle after its transfer.
// After byte 10 of a PCR packet input stalls for the PID search (StRead, StCmp per entry,
//   one read port), StDiv to divide by 90, then check, update and issue (StCheck to StDone).
// Throughput: one byte per cycle outside the search while the result register is free.
// Reset: asynchronous active low; clears parser state, entry count and output valid.
//   The PID table needs no clearing pass: only entries below the count are ever read.
module ts_pcr_pacing_parser_unit #(
  parameter int unsigned TABLE_ENTRIES = tpp_pkg::TableEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpp_byte_if.sink    byte_in_i,
  tpp_res_if.source   res_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import tpp_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(TABLE_ENTRIES);

  // sequencer states
  localparam logic [2:0] StRun   = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StCmp   = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StCheck = 3'd4;
  localparam logic [2:0] StApply = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  // ---------------- configuration ----------------
  logic [31:0] max_wait_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_wait_q <= MaxWaitReset;
    end else if (psel_i && penable_i && pwrite_i && paddr_i == RegMaxWait) begin
      max_wait_q <= pwdata_i;
    end
  end
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == RegMaxWait) ? max_wait_q : 32'd0;

  // ---------------- state ----------------
  logic [2:0]       state_q, state_d;
  logic [7:0]       pos_q, pos_d;
  logic [PidW-1:0]  pid_q, pid_d;
  logic [2:0]       flags_q, flags_d;
  logic [PcrW-1:0]  pcr_q, pcr_d;
  logic [TimeW-1:0] pst_q, pst_d;       // pass start time
  logic [TimeW-1:0] now_q, now_d;       // time of the byte-10 transfer
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  idx_q, idx_d;

  // per-packet work registers
  logic [TimeW-1:0] elapsed_q, elapsed_d;
  logic [TgtW-1:0]  target_q, target_d;
  logic [TgtW-1:0]  diff_q, diff_d;
  logic             lt_q, lt_d;
  logic             paced_q, paced_d;
  logic [31:0]      wait_q, wait_d;

  // result register
  logic             ov_q, ov_d;
  logic             okind_q, okind_d;
  logic [PidW-1:0]  opid_q, opid_d;
  logic [PcrW-1:0]  opcr_q, opcr_d;
  logic             opaced_q, opaced_d;
  logic [31:0]      owait_q, owait_d;

  // PID table: one memory, synchronous read
  entry_t          mem [TABLE_ENTRIES];
  entry_t          rd_q;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state_q == StRead) begin
      rd_q <= mem[idx_q];
    end
  end

  // divide unit for the PCR delta
  logic            div_start;
  logic [PcrW-1:0] div_num;
  logic            div_done;
  logic [QuoW-1:0] div_quo;

  tpp_div90 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  logic       slot_free;
  logic       in_xfer;
  logic [7:0] b;
  logic [7:0] pos_eff;
  logic       hit;
  logic       last_idx;
  logic [TgtW-1:0] quo_ext;

  assign slot_free       = !ov_q || res_o.ready;
  assign byte_in_i.ready = (state_q == StRun) && slot_free;
  assign in_xfer         = byte_in_i.valid && byte_in_i.ready;
  assign b               = byte_in_i.stream_byte;
  assign pos_eff         = byte_in_i.pass_start ? 8'd0 : pos_q;
  assign hit             = rd_q.pid == pid_q;
  assign last_idx        = CntW'(idx_q) + CntW'(1) == count_q;
  assign div_num         = pcr_q - rd_q.prev_pcr;
  assign quo_ext         = TgtW'(div_quo);

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    pid_d     = pid_q;
    flags_d   = flags_q;
    pcr_d     = pcr_q;
    pst_d     = pst_q;
    now_d     = now_q;
    count_d   = count_q;
    idx_d     = idx_q;
    elapsed_d = elapsed_q;
    target_d  = target_q;
    diff_d    = diff_q;
    lt_d      = lt_q;
    paced_d   = paced_q;
    wait_d    = wait_q;
    ov_d      = ov_q && !res_o.ready;
    okind_d   = okind_q;
    opid_d    = opid_q;
    opcr_d    = opcr_q;
    opaced_d  = opaced_q;
    owait_d   = owait_q;
    wr_en     = 1'b0;
    wr_addr   = idx_q;
    wr_data   = rd_q;
    div_start = 1'b0;

    unique case (state_q)
      StRun: begin
        if (in_xfer) begin
          if (byte_in_i.pass_start) begin
            count_d = '0;
            pst_d   = byte_in_i.now_us;
          end
          if (pos_eff == 8'd0) begin
            if (b != SyncByte) begin
              ov_d     = 1'b1;
              okind_d  = 1'(ResKindSyncErr);
              opid_d   = '0;
              opcr_d   = '0;
              opaced_d = 1'b0;
              owait_d  = '0;
              pos_d    = 8'd0;
            end else begin
              pid_d   = '0;
              flags_d = '0;
              pcr_d   = '0;
              pos_d   = 8'd1;
            end
          end else begin
            case (pos_eff)
              8'd1:  pid_d = {b[4:0], 8'd0};
              8'd2:  pid_d = pid_q | PidW'(b);
              8'd3:  if (b[5]) flags_d = flags_q | 3'b001;
              8'd4:  if (b != 8'd0) flags_d = flags_q | 3'b010;
              8'd5:  if (b[4]) flags_d = flags_q | 3'b100;
              8'd6:  pcr_d = {b, 25'd0};
              8'd7:  pcr_d = pcr_q | {8'd0, b, 17'd0};
              8'd8:  pcr_d = pcr_q | {16'd0, b, 9'd0};
              8'd9:  pcr_d = pcr_q | {24'd0, b, 1'b0};
              8'd10: pcr_d = pcr_q | {32'd0, b[7]};
              default: ;
            endcase
            pos_d = (pos_eff + 8'd1 >= PktLen) ? 8'd0 : pos_eff + 8'd1;
            if (pos_eff == PcrReportPos && flags_q == FlagsAllSet) begin
              now_d   = byte_in_i.now_us;
              paced_d = 1'b0;
              wait_d  = '0;
              idx_d   = '0;
              state_d = (count_q == '0) ? StCmp : StRead;
            end
          end
        end
      end
      StRead: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (count_q != '0 && hit) begin
          if (!rd_q.seen) begin
            wr_en            = 1'b1;
            wr_data.prev_pcr = pcr_q;
            wr_data.seen     = 1'b1;
            state_d          = StDone;
          end else if (pcr_q < rd_q.prev_pcr || now_q <= rd_q.pace_t0) begin
            state_d = StDone;
          end else begin
            div_start = 1'b1;
            elapsed_d = now_q - rd_q.pace_t0;
            state_d   = StDiv;
          end
        end else if (count_q == '0 || last_idx) begin
          // unknown PID: record it if room, first PCR has no wait
          if (count_q < CntMax) begin
            wr_en            = 1'b1;
            wr_addr          = count_q[IdxW-1:0];
            wr_data.pid      = pid_q;
            wr_data.prev_pcr = pcr_q;
            wr_data.pace_t0  = pst_q;
            wr_data.seen     = 1'b1;
            count_d          = count_q + CntW'(1);
          end
          state_d = StDone;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = StRead;
        end
      end
      StDiv: begin
        if (div_done) begin
          target_d = (quo_ext << 10) - (quo_ext << 4) - (quo_ext << 3);
          state_d  = StCheck;
        end
      end
      StCheck: begin
        lt_d    = elapsed_q < TimeW'(target_q);
        diff_d  = target_q - elapsed_q[TgtW-1:0];
        state_d = StApply;
      end
      StApply: begin
        if (lt_q && diff_q < TgtW'(max_wait_q)) begin
          paced_d          = 1'b1;
          wait_d           = diff_q[31:0];
          wr_en            = 1'b1;
          wr_data.prev_pcr = pcr_q;
          wr_data.pace_t0  = now_q + TimeW'(diff_q[31:0]);
        end
        state_d = StDone;
      end
      StDone: begin
        if (slot_free) begin
          ov_d     = 1'b1;
          okind_d  = 1'(ResKindPcr);
          opid_d   = pid_q;
          opcr_d   = pcr_q;
          opaced_d = paced_q;
          owait_d  = wait_q;
          state_d  = StRun;
        end
      end
      default: state_d = StRun;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
      pos_q   <= '0;
      pid_q   <= '0;
      flags_q <= '0;
      pcr_q   <= '0;
      pst_q   <= '0;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      pid_q   <= pid_d;
      flags_q <= flags_d;
      pcr_q   <= pcr_d;
      pst_q   <= pst_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    idx_q     <= idx_d;
    elapsed_q <= elapsed_d;
    target_q  <= target_d;
    diff_q    <= diff_d;
    lt_q      <= lt_d;
    paced_q   <= paced_d;
    wait_q    <= wait_d;
    okind_q   <= okind_d;
    opid_q    <= opid_d;
    opcr_q    <= opcr_d;
    opaced_q  <= opaced_d;
    owait_q   <= owait_d;
  end

  assign res_o.valid     = ov_q;
  assign res_o.kind      = okind_q;
  assign res_o.pid       = opid_q;
  assign res_o.pcr_value = opcr_q;
  assign res_o.paced     = opaced_q;
  assign res_o.wait_us   = owait_q;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax) else $error("entry count beyond table size");

  a_wait_only_paced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !opaced_q |-> owait_q == '0) else $error("wait without pacing");

  a_sync_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && okind_q == 1'(ResKindSyncErr) |-> opid_q == '0 && !opaced_q)
    else $error("sync error result carries data");

  a_no_input_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StRun |-> !byte_in_i.ready) else $error("input taken during search");

endmodule
